@@ design/c2p_pkg.sv @@
package c2p_pkg;

    localparam int COORD_BITS    = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    // datapath widths
    localparam int SCALE_SH = 60 - COORD_BITS;
    localparam int CW       = 62;
    localparam int SW       = 2 * COORD_BITS;
    localparam int ZW       = 32;
    localparam int NSTG     = (CORDIC_STAGES > COORD_BITS) ? CORDIC_STAGES : COORD_BITS;

    localparam int S_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((COORD_BITS + ANGLE_BITS + 1 + 7) / 8) * 8;

    localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ZW-1:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ZW-1:0]        z;
        logic [SW-1:0]        rem;
        logic [SW-1:0]        root;
        logic                 origin;
    } c2p_work_t;

endpackage

@@ design/c2p_front.sv @@
module c2p_front
    import c2p_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] x_coord,
    input  logic signed [COORD_BITS-1:0] y_coord,
    output logic                         out_valid,
    input  logic                         out_ready,
    output c2p_work_t                    out_work
);

    logic                  v1_reg;
    logic                  v2_reg;
    logic                  rdy1;
    logic                  rdy2;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic signed [CW-1:0]  xe;
    logic signed [CW-1:0]  ye;
    logic [SW-1:0]         sqx_reg;
    logic [SW-1:0]         sqy_reg;
    c2p_work_t             w1_next;
    c2p_work_t             w1_reg;
    c2p_work_t             w2_next;
    c2p_work_t             w2_reg;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        ax = x_coord[COORD_BITS-1] ? COORD_BITS'(-x_coord) : x_coord;
        ay = y_coord[COORD_BITS-1] ? COORD_BITS'(-y_coord) : y_coord;
        xe = {{(CW-COORD_BITS){x_coord[COORD_BITS-1]}}, x_coord} <<< SCALE_SH;
        ye = {{(CW-COORD_BITS){y_coord[COORD_BITS-1]}}, y_coord} <<< SCALE_SH;
        w1_next        = '0;
        w1_next.origin = (x_coord == '0) && (y_coord == '0);
        if (x_coord[COORD_BITS-1]) begin
            w1_next.x = -xe;
            w1_next.y = -ye;
            w1_next.z = HALF_TURN;
        end else begin
            w1_next.x = xe;
            w1_next.y = ye;
        end
    end

    always_comb begin
        w2_next     = w1_reg;
        w2_next.rem = sqx_reg + sqy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            w1_reg  <= w1_next;
            sqx_reg <= SW'(ax) * SW'(ax);
            sqy_reg <= SW'(ay) * SW'(ay);
        end
        if (rdy2) begin
            w2_reg <= w2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_work  = w2_reg;

endmodule

@@ design/c2p_core.sv @@
module c2p_core
    import c2p_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  c2p_work_t in_work,
    output logic      out_valid,
    input  logic      out_ready,
    output c2p_work_t out_work
);

    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_in;
    c2p_work_t       w_in   [NSTG];
    c2p_work_t       w_next [NSTG];
    c2p_work_t       w_reg  [NSTG];

    assign rdy[NSTG] = out_ready;
    assign in_ready  = rdy[0];

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [ZW-1:0]        cz;
        logic [SW-1:0]        srem;
        logic [SW-1:0]        sroot;

        if (k == 0) begin : g_first
            assign w_in[k] = in_work;
            assign v_in[k] = in_valid;
        end else begin : g_next
            assign w_in[k] = w_reg[k-1];
            assign v_in[k] = v_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        if (k < CORDIC_STAGES) begin : g_rot
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            always_comb begin
                xs = w_in[k].x >>> k;
                ys = w_in[k].y >>> k;
                if (!w_in[k].y[CW-1]) begin
                    cx = w_in[k].x + ys;
                    cy = w_in[k].y - xs;
                    cz = w_in[k].z + ATAN_TAB[k];
                end else begin
                    cx = w_in[k].x - ys;
                    cy = w_in[k].y + xs;
                    cz = w_in[k].z - ATAN_TAB[k];
                end
            end
        end else begin : g_norot
            assign cx = w_in[k].x;
            assign cy = w_in[k].y;
            assign cz = w_in[k].z;
        end

        if (k < COORD_BITS) begin : g_sqrt
            localparam logic [SW-1:0] BIT = SW'(1) << (2 * (COORD_BITS - 1 - k));
            logic [SW-1:0] t;
            always_comb begin
                t = w_in[k].root + BIT;
                if (w_in[k].rem >= t) begin
                    srem  = w_in[k].rem - t;
                    sroot = (w_in[k].root >> 1) + BIT;
                end else begin
                    srem  = w_in[k].rem;
                    sroot = w_in[k].root >> 1;
                end
            end
        end else begin : g_nosqrt
            assign srem  = w_in[k].rem;
            assign sroot = w_in[k].root;
        end

        always_comb begin
            w_next[k]        = w_in[k];
            w_next[k].x      = cx;
            w_next[k].y      = cy;
            w_next[k].z      = cz;
            w_next[k].rem    = srem;
            w_next[k].root   = sroot;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                w_reg[k] <= w_next[k];
            end
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_work  = w_reg[NSTG-1];

endmodule

@@ design/c2p_back.sv @@
module c2p_back
    import c2p_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  c2p_work_t             in_work,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] radius,
    output logic [ANGLE_BITS:0]   angle,
    output logic                  at_origin
);

    localparam logic [ZW:0] FULL_TURN = {1'b1, {ZW{1'b0}}};
    localparam logic [ZW:0] RND       = (ZW+1)'(1) << (ZW - 1 - ANGLE_BITS);

    logic                  v_reg;
    logic                  rdy;
    logic [ZW:0]           d;
    logic [ZW:0]           dr;
    logic [ANGLE_BITS:0]   ang;
    logic [COORD_BITS-1:0] radius_next;
    logic [ANGLE_BITS:0]   angle_next;
    logic [COORD_BITS-1:0] radius_reg;
    logic [ANGLE_BITS:0]   angle_reg;
    logic                  origin_reg;

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    always_comb begin
        d   = FULL_TURN - {1'b0, in_work.z};
        dr  = d + RND;
        ang = dr[ZW:ZW-ANGLE_BITS];
        if (in_work.origin) begin
            angle_next = '0;
        end else if (ang == '0) begin
            angle_next = {1'b1, {ANGLE_BITS{1'b0}}};
        end else begin
            angle_next = ang;
        end
        radius_next = COORD_BITS'(in_work.root + SW'(in_work.rem > in_work.root));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (rdy) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy) begin
            radius_reg <= radius_next;
            angle_reg  <= angle_next;
            origin_reg <= in_work.origin;
        end
    end

    assign out_valid = v_reg;
    assign radius    = radius_reg;
    assign angle     = angle_reg;
    assign at_origin = origin_reg;

endmodule

@@ design/cartesian_to_polar.sv @@
// channel  dir  tdata (low bit up)                         tuser
// s_       in   x_coord[15:0], y_coord[31:16]              -
// m_       out  radius[15:0], angle[32:16], zero pad       at_origin
//
// One word per cycle in and out while m_ does not stall; two front stages
// (squares, sum), 16 stages of combined CORDIC rotation and root digit,
// one output stage for rounding.
// Reset clears the valid bits only.
// A stall at m_ backs up stage by stage; empty stages keep filling.
module cartesian_to_polar
    import c2p_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // x_coord, y_coord
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // radius, angle, zero pad
    output logic                 m_tuser    // at_origin
);

    logic                  f_valid;
    logic                  f_ready;
    c2p_work_t             f_work;
    logic                  c_valid;
    logic                  c_ready;
    c2p_work_t             c_work;
    logic [COORD_BITS-1:0] radius;
    logic [ANGLE_BITS:0]   angle;
    logic                  at_origin;

    c2p_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_coord   (s_tdata[COORD_BITS-1:0]),
        .y_coord   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_work  (f_work)
    );

    c2p_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_work   (f_work),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_work  (c_work)
    );

    c2p_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_work   (c_work),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .radius    (radius),
        .angle     (angle),
        .at_origin (at_origin)
    );

    assign m_tdata = M_TDATA_W'({angle, radius});
    assign m_tuser = at_origin;

`ifndef SYNTHESIS
    a_origin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> angle == '0 && radius == '0)
        else $error("origin word with nonzero angle or radius");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> angle != '0 &&
            angle <= {1'b1, {ANGLE_BITS{1'b0}}})
        else $error("angle out of range");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled while output side is free");
`endif

endmodule

@@ dv/cartesian_to_polar_test.sv @@
`timescale 1ns / 100ps

module cartesian_to_polar_test;
    import c2p_pkg::*;

    localparam int LATENCY    = 19;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_LEN  = 500;

    typedef struct packed {
        logic [COORD_BITS-1:0] radius;
        logic [ANGLE_BITS:0]   angle;
        logic                  at_origin;
    } polar_t;

    // arctangent of 2^-i, 2^-32 turn units
    localparam logic [31:0] ARCTAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // x_coord, y_coord
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // radius, angle, zero pad
    logic                 m_tuser;    // at_origin

    polar_t pending_polar[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    int     idle_cycles = 0;
    int     n_points    = 0;
    int     n_results   = 0;
    int     n_origin    = 0;
    int     n_errors    = 0;

    cartesian_to_polar DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic polar_t polar_of(input logic signed [COORD_BITS-1:0] xc,
                                        input logic signed [COORD_BITS-1:0] yc);
        longint          xv;
        longint          yv;
        longint          xs;
        longint          ys;
        longint unsigned sq;
        longint unsigned rt;
        longint unsigned trial;
        logic [31:0]     zacc;
        logic [32:0]     cw;
        logic [33:0]     rnd;
        polar_t          r;
        xv = longint'(xc);
        yv = longint'(yc);
        sq = xv * xv + yv * yv;
        rt = '0;
        for (int b = COORD_BITS - 1; b >= 0; b--) begin
            trial = rt | (64'd1 << b);
            if (trial * trial <= sq)
                rt = trial;
        end
        if (sq - rt * rt > rt)
            rt = rt + 64'd1;
        r.radius = rt[COORD_BITS-1:0];
        if (xc == '0 && yc == '0) begin
            r.angle     = '0;
            r.at_origin = 1'b1;
            return r;
        end
        xv   = xv <<< (60 - COORD_BITS);
        yv   = yv <<< (60 - COORD_BITS);
        zacc = 32'h0;
        if (xv < 0) begin
            xv   = -xv;
            yv   = -yv;
            zacc = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
                xv   = xv + ys;
                yv   = yv - xs;
                zacc = zacc + ARCTAN_STEP[i % 32];
            end else begin
                xv   = xv - ys;
                yv   = yv + xs;
                zacc = zacc - ARCTAN_STEP[i % 32];
            end
        end
        cw  = 33'h1_0000_0000 - {1'b0, zacc};
        rnd = {1'b0, cw} + (34'd1 << (31 - ANGLE_BITS));
        r.angle = rnd[32 - ANGLE_BITS +: ANGLE_BITS + 1];
        if (r.angle == '0)
            r.angle = {1'b1, {ANGLE_BITS{1'b0}}};
        r.at_origin = 1'b0;
        return r;
    endfunction

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // scoreboard and watchdog
    always @(posedge aclk) begin
        polar_t exp_p;
        polar_t got_p;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_p.radius    = m_tdata[COORD_BITS-1:0];
                got_p.angle     = m_tdata[COORD_BITS +: ANGLE_BITS + 1];
                got_p.at_origin = m_tuser;
                n_results++;
                if (pending_polar.size() == 0) begin
                    $display("%0t: unexpected word radius %0d angle %0d origin %0b",
                             $time, got_p.radius, got_p.angle, got_p.at_origin);
                    n_errors++;
                end else begin
                    exp_p = pending_polar.pop_front();
                    if (got_p.radius !== exp_p.radius) begin
                        $display("%0t: radius expected %0d actual %0d",
                                 $time, exp_p.radius, got_p.radius);
                        n_errors++;
                    end
                    if (got_p.angle !== exp_p.angle) begin
                        $display("%0t: angle expected %0d actual %0d",
                                 $time, exp_p.angle, got_p.angle);
                        n_errors++;
                    end
                    if (got_p.at_origin !== exp_p.at_origin) begin
                        $display("%0t: at_origin expected %0b actual %0b",
                                 $time, exp_p.at_origin, got_p.at_origin);
                        n_errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                exp_p = polar_of(s_tdata[COORD_BITS-1:0],
                                 s_tdata[COORD_BITS +: COORD_BITS]);
                if (exp_p.at_origin)
                    n_origin++;
                pending_polar = {pending_polar, exp_p};
                n_points++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                    $display("cartesian_to_polar_test: FAIL");
                    $finish;
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_point(input logic signed [COORD_BITS-1:0] xc,
                              input logic signed [COORD_BITS-1:0] yc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {yc, xc};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_polar.size() != 0)
            @(negedge aclk);
    endtask

    task automatic pick_point(output logic signed [COORD_BITS-1:0] xc,
                              output logic signed [COORD_BITS-1:0] yc);
        logic signed [COORD_BITS-1:0] corner [6];
        int kind;
        int mag;
        corner = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};
        kind   = $urandom_range(11);
        xc     = COORD_BITS'($urandom);
        yc     = COORD_BITS'($urandom);
        case (kind)
            0: begin
                xc = COORD_BITS'($urandom_range(8) - 4);
                yc = COORD_BITS'($urandom_range(8) - 4);
            end
            1: begin
                if ($urandom_range(1)) xc = '0;
                else yc = '0;
            end
            2: begin
                mag = $urandom_range(32767);
                xc  = COORD_BITS'($urandom_range(1) ? -mag : mag);
                yc  = COORD_BITS'($urandom_range(1) ? -mag : mag);
            end
            3: begin
                xc = corner[3'($urandom_range(5))];
                yc = corner[3'($urandom_range(5))];
            end
            4: begin
                // near the positive x axis, where the angle wraps to a full turn
                xc = COORD_BITS'($urandom_range(32767, 1));
                yc = COORD_BITS'($urandom_range(6) - 3);
            end
            5: begin
                if ($urandom_range(1)) xc = COORD_BITS'($urandom_range(6) - 3);
                else yc = COORD_BITS'($urandom_range(6) - 3);
            end
            default: ;
        endcase
    endtask

    task automatic run_random(input int count);
        logic signed [COORD_BITS-1:0] xc;
        logic signed [COORD_BITS-1:0] yc;
        for (int k = 0; k < count; k++) begin
            pick_point(xc, yc);
            send_point(xc, yc);
        end
        wait_all_results();
    endtask

    task automatic test_directed_points();
        logic signed [COORD_BITS-1:0] pts [24][2];
        pts = '{
            '{16'sd0, 16'sd0},           '{16'sh7FFF, 16'sd0},
            '{16'sh8000, 16'sd0},        '{16'sd0, 16'sh7FFF},
            '{16'sd0, 16'sh8000},        '{16'sh8000, 16'sh8000},
            '{16'sh7FFF, 16'sh7FFF},     '{16'sh8000, 16'sh7FFF},
            '{16'sh7FFF, 16'sh8000},     '{16'sd1, 16'sd0},
            '{16'sd0, 16'sd1},           '{-16'sd1, 16'sd0},
            '{16'sd0, -16'sd1},          '{16'sh7FFF, -16'sd1},
            '{16'sh7FFF, 16'sd1},        '{16'sd1, -16'sd1},
            '{-16'sd1, 16'sd1},          '{-16'sd1, -16'sd1},
            '{16'sd1, 16'sd1},           '{16'sh8000, -16'sd1},
            '{16'sh8000, 16'sd1},        '{16'sd3, 16'sd4},
            '{-16'sd12, 16'sd5},         '{16'sd0, 16'sd0}
        };
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (pts[i])
            send_point(pts[i][0], pts[i][1]);
        wait_all_results();
    endtask

    task automatic test_streaming();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(PHASE_LEN);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 58;
        recv_stall_pct = 0;
        run_random(PHASE_LEN);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        run_random(PHASE_LEN);
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        run_random(PHASE_LEN);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_points();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        repeat (2 * LATENCY) @(posedge aclk);
        $display("%0d points converted, %0d words checked (%0d at the origin)",
                 n_points, n_results, n_origin);
        $display("axes, corners, diagonals and full-range points under four idle mixes");
        if (n_errors == 0) begin
            $display("cartesian_to_polar_test: PASS");
        end else begin
            $display("cartesian_to_polar_test: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/c2p_pkg.sv
design/c2p_front.sv
design/c2p_core.sv
design/c2p_back.sv
design/cartesian_to_polar.sv
dv/cartesian_to_polar_test.sv
